[src/scan_polar_to_cartesian_core_macros.svh]
// assertion macros for the scan polar to cartesian core
// no dependencies; taken in by `include in the files that check their logic
`ifndef SCAN_POLAR_TO_CARTESIAN_CORE_MACROS_SVH
`define SCAN_POLAR_TO_CARTESIAN_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SPC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("scan_polar_to_cartesian_core: check failed");
`define SPC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scan_polar_to_cartesian_core: implication failed");
`else
`define SPC_ASSERT(lbl, clk, rst, prop)
`define SPC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`endif
`endif

[src/spc_pkg.sv]
// shared types, constants and the arctangent table of the scan polar to cartesian core
// no dependencies
package spc_pkg;

  localparam int CORDIC_STEPS = 18;
  localparam int ROT_STEPS    = (CORDIC_STEPS > 30) ? 30 : CORDIC_STEPS;
  localparam int STEP_W       = $clog2(ROT_STEPS);

  // angles in 1/10000 degree
  localparam logic [22:0] FULL_TURN      = 23'd3600000;
  localparam logic [21:0] QUARTER_TURN   = 22'd900000;
  localparam logic [21:0] THREE_QUARTERS = 22'd2700000;
  // 2^32 is 1193 full turns plus 128 * 1307, the half turn is 128 * 14062 plus 64
  localparam logic [10:0] TURN_WHOLE     = 11'd1193;
  localparam logic [10:0] TURN_PART      = 11'd1307;
  localparam logic [13:0] PART_RND       = 14'd14062;
  // 2^46 / 28125 rounded up, exact for dividends below 2^33
  localparam logic [31:0] RECIP_28125    = 32'd2501999793;
  localparam int          RECIP_SHIFT    = 46;

  // cordic gain compensation, 31 bit fraction
  localparam logic [30:0] GAIN_K = 31'd1304065748;

  localparam int XY_W  = 48;
  localparam int Z_W   = 33;
  localparam int D_W   = 30;
  localparam int MAG_W = 29;

  localparam logic [23:0]        RST_RANGE_GAIN   = 24'd65536;
  localparam logic signed [19:0] RST_RANGE_OFFSET = 20'sd0;
  localparam logic signed [22:0] RST_FIRST_ANGLE  = -23'sd450000;
  localparam logic [18:0]        RST_ANGLE_STEP   = 19'd3333;

  typedef enum logic [1:0] {
    REG_RANGE_GAIN   = 2'd0,
    REG_RANGE_OFFSET = 2'd1,
    REG_FIRST_ANGLE  = 2'd2,
    REG_ANGLE_STEP   = 2'd3
  } spc_cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_DIST,
    S_DIV,
    S_DHI,
    S_QUOT,
    S_MLO,
    S_MHI,
    S_SCALE,
    S_ROT,
    S_FIN
  } spc_state_t;

  // arctangent of 2^-i in 2^-32 turn units
  function automatic logic [29:0] atan_val(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

[src/scan_polar_to_cartesian_core.sv]
// scan polar to cartesian core: range scaling, beam angle tracking and iterative cordic
// depends on spc_pkg and scan_polar_to_cartesian_core_macros.svh

// Takes one range word at a time, scales it to a distance in 1/16 mm, tracks the beam
// angle (reloaded from first_angle by scan_start, advanced by angle_step modulo a full
// turn) and rotates the distance into pos_x/pos_y with a shared cordic datapath. A word
// occupies the core from acceptance until its result is loaded: S_PREP for angle prep,
// S_DIST for distance, S_DIV, S_DHI and S_QUOT that turn the angle into binary turns
// through a reciprocal multiply split in two halves, S_MLO, S_MHI and S_SCALE for the
// gain multiply split in two halves, one rotation per cycle in S_ROT, and S_FIN to round
// and saturate, which waits while a stalled result still sits in the output register.
// The next word can be taken in the cycle after the result is loaded, not before.
// in_stall is high while a word is being worked on.
`include "scan_polar_to_cartesian_core_macros.svh"

module scan_polar_to_cartesian_core
  import spc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [15:0]         raw_range,
  input  logic                scan_start,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [27:0]  pos_x,
  output logic signed [27:0]  pos_y
);

  function automatic logic signed [27:0] sat28(input logic signed [XY_W-1:0] v);
    logic signed [27:0] r;
    if (v > 48'sd134217727) begin
      r = 28'sh7FFFFFF;
    end else if (v < -48'sd134217728) begin
      r = 28'sh8000000;
    end else begin
      r = v[27:0];
    end
    return r;
  endfunction

  spc_state_t state, state_next;

  logic [23:0]             range_gain;
  logic signed [19:0]      range_offset;
  logic signed [22:0]      first_angle;
  logic [18:0]             angle_step;
  logic [21:0]             beam_angle;

  logic [15:0]             raw;
  logic [21:0]             theta;
  logic [39:0]             prod;
  logic signed [D_W-1:0]   distance;
  logic [MAG_W-1:0]        mag;
  logic                    dneg;
  logic [32:0]             part;
  logic [31:0]             whole;
  logic [47:0]             rlo;
  logic [48:0]             rhi;
  logic [31:0]             quot;
  logic [44:0]             plo;
  logic [43:0]             phi;
  logic                    negf;
  logic signed [XY_W-1:0]  x;
  logic signed [XY_W-1:0]  y;
  logic signed [Z_W-1:0]   z;
  logic [STEP_W-1:0]       step;

  // combinational helpers
  logic signed [23:0]      fa;
  logic signed [23:0]      fa_wrap;
  logic [21:0]             load_angle;
  logic [22:0]             beam_sum;
  logic [40:0]             prod_rnd;
  logic signed [D_W-1:0]   dist_sum;
  logic [64:0]             recip_sum;
  logic [31:0]             quot_sum;
  logic signed [Z_W-1:0]   zq;
  logic signed [Z_W-1:0]   zf;
  logic                    fold;
  logic [60:0]             scale_sum;
  logic signed [XY_W-1:0]  xs;
  logic signed [XY_W-1:0]  ys;
  logic signed [Z_W-1:0]   atn;
  logic signed [XY_W-1:0]  xn;
  logic signed [XY_W-1:0]  yn;
  logic signed [XY_W-1:0]  xr;
  logic signed [XY_W-1:0]  yr;

  always_comb begin
    // first angle reduced into one turn
    fa = {first_angle[22], first_angle};
    if (fa < -24'sd3600000) begin
      fa_wrap = fa + 24'sd7200000;
    end else if (fa < 24'sd0) begin
      fa_wrap = fa + 24'sd3600000;
    end else if (fa >= 24'sd3600000) begin
      fa_wrap = fa - 24'sd3600000;
    end else begin
      fa_wrap = fa;
    end
    load_angle = fa_wrap[21:0];

    beam_sum = {1'b0, beam_angle} + {4'b0000, angle_step};

    prod_rnd = {1'b0, prod} + 41'd2048;
    dist_sum = signed'({2'b00, prod_rnd[39:12]}) + D_W'(range_offset);

    // part / 28125 by reciprocal multiply, added to the whole turns
    recip_sum = 65'(rlo) + {rhi, 16'h0000};
    quot_sum  = whole + 32'(recip_sum[64:RECIP_SHIFT]);

    // fold the binary angle into the right half plane
    zq = signed'({quot[31], quot});
    if (zq > 33'sd1073741824) begin
      zf   = zq - 33'sd2147483648;
      fold = 1'b1;
    end else if (zq < -33'sd1073741824) begin
      zf   = zq + 33'sd2147483648;
      fold = 1'b1;
    end else begin
      zf   = zq;
      fold = 1'b0;
    end

    scale_sum = 61'(plo) + {1'b0, phi, 16'h0000} + 61'd16384;

    xs  = x >>> step;
    ys  = y >>> step;
    atn = signed'({3'b000, atan_val(5'(step))});

    xn = negf ? -x : x;
    yn = negf ? -y : y;
    xr = (xn + 48'sd32768) >>> 16;
    yr = (yn + 48'sd32768) >>> 16;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = (state != S_IDLE);
    case (state)
      S_IDLE:  if (in_valid) state_next = S_PREP;
      S_PREP:  state_next = S_DIST;
      S_DIST:  state_next = S_DIV;
      S_DIV:   state_next = S_DHI;
      S_DHI:   state_next = S_QUOT;
      S_QUOT:  state_next = S_MLO;
      S_MLO:   state_next = S_MHI;
      S_MHI:   state_next = S_SCALE;
      S_SCALE: state_next = S_ROT;
      S_ROT:   if (step == STEP_W'(ROT_STEPS - 1)) state_next = S_FIN;
      S_FIN:   if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // configuration and beam angle
  always_ff @(posedge clk) begin
    if (rst) begin
      range_gain   <= RST_RANGE_GAIN;
      range_offset <= RST_RANGE_OFFSET;
      first_angle  <= RST_FIRST_ANGLE;
      angle_step   <= RST_ANGLE_STEP;
      beam_angle   <= 22'd0;
    end else begin
      if (cfg_write) begin
        case (spc_cfg_reg_t'(cfg_index))
          REG_RANGE_GAIN:   range_gain   <= cfg_data;
          REG_RANGE_OFFSET: range_offset <= cfg_data[19:0];
          REG_FIRST_ANGLE:  first_angle  <= cfg_data[22:0];
          REG_ANGLE_STEP:   angle_step   <= cfg_data[18:0];
          default: ;
        endcase
      end
      if (state == S_IDLE && in_valid && scan_start) begin
        beam_angle <= load_angle;
      end else if (state == S_PREP) begin
        beam_angle <= (beam_sum >= FULL_TURN) ? 22'(beam_sum - FULL_TURN) : beam_sum[21:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && (!out_valid || !out_stall)) begin
      pos_x <= sat28(xr);
      pos_y <= sat28(yr);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            raw <= raw_range;
          end
        end
        S_PREP: begin
          theta <= (beam_angle >= QUARTER_TURN) ? beam_angle - QUARTER_TURN
                                                : beam_angle + THREE_QUARTERS;
          prod  <= 40'(raw) * 40'(range_gain);
        end
        S_DIST: begin
          distance <= dist_sum;
          part     <= 33'(theta) * 33'(TURN_PART) + 33'(PART_RND);
          whole    <= 32'(theta) * 32'(TURN_WHOLE);
        end
        S_DIV: begin
          rlo  <= 48'(part[15:0]) * 48'(RECIP_28125);
          mag  <= distance[D_W-1] ? MAG_W'(-distance) : MAG_W'(distance);
          dneg <= distance[D_W-1];
        end
        S_DHI: begin
          rhi <= 49'(part[32:16]) * 49'(RECIP_28125);
        end
        S_QUOT: begin
          quot <= quot_sum;
        end
        S_MLO: begin
          z    <= zf;
          negf <= dneg ^ fold;
          plo  <= 45'(mag) * 45'(GAIN_K[15:0]);
        end
        S_MHI: begin
          phi <= 44'(mag) * 44'(GAIN_K[30:16]);
        end
        S_SCALE: begin
          x    <= signed'({2'b00, scale_sum[60:15]});
          y    <= '0;
          step <= '0;
        end
        S_ROT: begin
          if (z >= 0) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - atn;
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + atn;
          end
          step <= step + 1'b1;
        end
        default: ;
      endcase
    end
  end

  `SPC_ASSERT(a_beam_in_turn, clk, rst, {1'b0, beam_angle} < FULL_TURN)
  `SPC_ASSERT_IMP(a_idle_ready, clk, rst, state == S_IDLE, !in_stall)
  `SPC_ASSERT_IMP(a_rot_start_folded, clk, rst, state == S_ROT && step == '0,
                  z <= 33'sd1073741824 && z >= -33'sd1073741824)
  `SPC_ASSERT_IMP(a_result_from_fin, clk, rst, $rose(out_valid), $past(state == S_FIN))

endmodule

[bench/tb.sv]
// self-checking bench for scan_polar_to_cartesian_core: directed words, then random scans
// depends on spc_pkg and the core; holds its own fixed-point cordic predictor and scoreboard
module tb
  import spc_pkg::*;
();

  localparam longint TURN        = 3600000;
  localparam longint QUARTER     = 900000;
  localparam longint QUARTER_BIN = longint'(1) << 30;
  localparam longint HALF_BIN    = longint'(1) << 31;
  localparam longint FULL_BIN    = longint'(1) << 32;
  localparam longint CORDIC_GAIN = 1304065748;
  localparam int     QUIET_LIMIT = 3000;
  localparam int     HOLD_LEN    = 400;
  localparam int     PHASE_WORDS = 180;

  // arctan(2^-i) in 2^-32 turn units
  localparam longint ATAN_TURNS [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };

  typedef struct packed {
    logic signed [27:0] x;
    logic signed [27:0] y;
  } point_t;

  class point_board;
    logic [23:0]        dist_gain;
    logic signed [19:0] dist_offset;
    logic signed [22:0] start_angle;
    logic [18:0]        angle_inc;
    longint             beam;
    point_t             pending[$];
    int unsigned        fails;

    function new();
      dist_gain   = 24'd65536;
      dist_offset = '0;
      start_angle = -23'sd450000;
      angle_inc   = 19'd3333;
      beam        = 0;
      fails       = 0;
    endfunction

    function void set_reg(spc_cfg_reg_t idx, logic [23:0] val);
      case (idx)
        REG_RANGE_GAIN:   dist_gain   = val;
        REG_RANGE_OFFSET: dist_offset = val[19:0];
        REG_FIRST_ANGLE:  start_angle = val[22:0];
        REG_ANGLE_STEP:   angle_inc   = val[18:0];
        default: ;
      endcase
    endfunction

    function logic signed [27:0] clip28(longint v);
      if (v > 134217727) return 28'sh7FFFFFF;
      if (v < -134217728) return 28'sh8000000;
      return v[27:0];
    endfunction

    function void flag(string what);
      fails++;
      if (fails <= 10) $display("mismatch: %s", what);
    endfunction

    // predicts the point for one accepted word and advances the beam angle
    function void note_sample(logic [15:0] raw, logic start);
      longint d, mag, x, y, z, xs, ys, theta;
      bit     flip;
      point_t p;
      if (start) begin
        beam = longint'(start_angle) % TURN;
        if (beam < 0) beam += TURN;
      end
      d = ((longint'(raw) * longint'(dist_gain) + 2048) >>> 12) + longint'(dist_offset);
      flip = d < 0;
      mag = flip ? -d : d;
      theta = beam + TURN - QUARTER;
      if (theta >= TURN) theta -= TURN;
      z = ((theta << 32) + TURN / 2) / TURN;
      if (z >= HALF_BIN) z -= FULL_BIN;
      // fold into the right half plane with a half turn
      if (z > QUARTER_BIN) begin
        z -= HALF_BIN;
        flip = !flip;
      end else if (z < -QUARTER_BIN) begin
        z += HALF_BIN;
        flip = !flip;
      end
      x = (mag * CORDIC_GAIN + 16384) >>> 15;
      y = 0;
      for (int i = 0; i < ROT_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys;
          y += xs;
          z -= ATAN_TURNS[i];
        end else begin
          x += ys;
          y -= xs;
          z += ATAN_TURNS[i];
        end
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      p.x = clip28((x + 32768) >>> 16);
      p.y = clip28((y + 32768) >>> 16);
      pending.push_back(p);
      beam += angle_inc;
      if (beam >= TURN) beam -= TURN;
    endfunction

    function void check_point(logic signed [27:0] x, logic signed [27:0] y);
      point_t want;
      if (pending.size() == 0) begin
        flag($sformatf("unexpected point x=%0d y=%0d", x, y));
        return;
      end
      want = pending.pop_front();
      if (x !== want.x) flag($sformatf("pos_x expected %0d got %0d", want.x, x));
      if (y !== want.y) flag($sformatf("pos_y expected %0d got %0d", want.y, y));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  spc_cfg_reg_t       cfg_index = REG_RANGE_GAIN;
  logic [23:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [15:0]        raw_range = '0;
  logic               scan_start = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [27:0] pos_x;
  logic signed [27:0] pos_y;

  point_board  board = new();
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_taken = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet = 0;

  scan_polar_to_cartesian_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .raw_range  (raw_range),
    .scan_start (scan_start),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pos_x      (pos_x),
    .pos_y      (pos_y)
  );

  always #5 clk = ~clk;

  // receiver stall, with one long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // outputs are stable mid-cycle, so handshakes are judged at the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) board.check_point(pos_x, pos_y);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet == QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [15:0] raw, input logic start);
    bit taken;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    raw_range <= raw;
    scan_start <= start;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    board.note_sample(raw, start);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  task automatic put_reg(input spc_cfg_reg_t idx, input logic [23:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    board.set_reg(idx, val);
  endtask

  task automatic program_regs(input logic [23:0] gain, input logic [23:0] offs,
                              input logic [23:0] angle0, input logic [23:0] inc);
    put_reg(REG_RANGE_GAIN, gain);
    put_reg(REG_RANGE_OFFSET, offs);
    put_reg(REG_FIRST_ANGLE, angle0);
    put_reg(REG_ANGLE_STEP, inc);
    cfg_write <= 1'b0;
  endtask

  initial begin
    logic [23:0] g, o, f, s;
    logic        start;
    logic [15:0] raw;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings, beam angle not yet loaded by a scan start
    send_word(16'd500, 1'b0);
    send_word(16'd0, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'd4000, 1'b1);
    send_word(16'd4000, 1'b0);
    drain();

    // full gain and offset: saturation, eighth-turn steps all the way round
    program_regs(24'hFFFFFF, 24'h07FFFF, 24'd0, 24'd450000);
    for (int n = 0; n < 8; n++) send_word(16'hFFFF, n == 0);
    drain();

    // negative distance, most negative start angle, largest step
    program_regs(24'd0, 24'h080000, 24'h400000, 24'h07FFFF);
    for (int n = 0; n < 6; n++) send_word(16'($urandom), n == 0);
    drain();

    // smallest nonzero gain, largest start angle, no step
    program_regs(24'd1, 24'd0, 24'h3FFFFF, 24'd0);
    send_word(16'd0, 1'b1);
    send_word(16'hFFFF, 1'b0);
    send_word(16'hFFFF, 1'b1);
    send_word(16'd1, 1'b0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(3))
        0: g = 24'd65536;
        1: g = 24'($urandom_range(262143));
        2: g = 24'($urandom);
        default: g = 24'hFFFFFF;
      endcase
      case ($urandom_range(2))
        0: o = '0;
        1: o = 24'($urandom_range(4000) - 2000);
        default: o = 24'($urandom);
      endcase
      f = $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(3599999));
      case ($urandom_range(3))
        0: s = 24'($urandom_range(20000));
        1: s = 24'($urandom);
        2: s = '0;
        default: s = 24'd3333;
      endcase
      program_regs(g, o, f, s);

      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          send_idle_pct = 79;
          stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct <= 79;
        end
        default: begin
          send_idle_pct = 9;
          stall_pct <= 9;
        end
      endcase

      for (int n = 0; n < PHASE_WORDS; n++) begin
        // receiver holds off while words keep coming, so the core backs up
        if (ph == 0 && n == 20) hold_req <= 1'b1;
        if (ph == 6 && n == 90) drain();
        case ($urandom_range(9))
          0: raw = '0;
          1: raw = 16'hFFFF;
          2, 3, 4: raw = 16'($urandom_range(255));
          default: raw = 16'($urandom);
        endcase
        // one phase runs without an opening scan start
        start = (n == 0 && ph != 3) || $urandom_range(39) == 0;
        send_word(raw, start);
      end
      drain();
    end

    repeat (80) @(posedge clk);
    if (board.fails == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
